// ===== hw/rtl/calendar_field_adjust_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Calendar field adjust assertion macros
// Shared concurrent assertion forms for the calendar field adjust RTL.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_FIELD_ADJUST_UNIT_DEFINES_SVH
`define CALENDAR_FIELD_ADJUST_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define CFA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define CFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Calendar field adjust package
// Field types, operation and select codes, range limits.
// ----------------------------------------------------------------------------
package cfa_pkg;

  localparam int unsigned FIELD_W = 7;

  typedef logic [FIELD_W-1:0] field_t;
  // Candidate value after a move by one: -1 .. 128
  typedef logic signed [8:0] cand_t;
  typedef logic [4:0] mlen_t;

  typedef struct packed {
    field_t year;
    field_t month;
    field_t day_of_month;
    field_t hour;
    field_t minute;
    field_t second;
    field_t weekday;
  } fields_t;

  typedef enum logic [1:0] {
    OP_INC  = 2'd0,
    OP_DEC  = 2'd1,
    OP_LOAD = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    SEL_YEAR    = 3'd0,
    SEL_MONTH   = 3'd1,
    SEL_DAY     = 3'd2,
    SEL_HOUR    = 3'd3,
    SEL_MINUTE  = 3'd4,
    SEL_SECOND  = 3'd5,
    SEL_WEEKDAY = 3'd6,
    SEL_NONE    = 3'd7
  } sel_t;

  localparam field_t MONTH_JAN = 7'd1;
  localparam field_t MONTH_FEB = 7'd2;
  localparam field_t MONTH_APR = 7'd4;
  localparam field_t MONTH_JUN = 7'd6;
  localparam field_t MONTH_SEP = 7'd9;
  localparam field_t MONTH_NOV = 7'd11;
  localparam field_t MONTH_DEC = 7'd12;

  localparam mlen_t LEN_UNKNOWN = 5'd0;
  localparam mlen_t LEN_FEB     = 5'd28;
  localparam mlen_t LEN_FEB_LEAP = 5'd29;
  localparam mlen_t LEN_SHORT   = 5'd30;
  localparam mlen_t LEN_LONG    = 5'd31;

  localparam cand_t DAY_MIN     = 9'sd1;
  localparam cand_t DAY_RAW_MIN = 9'sd0;
  localparam cand_t DAY_RAW_MAX = 9'sd99;

  function automatic cand_t range_lo(sel_t sel);
    cand_t lo;
    unique case (sel)
      SEL_MONTH, SEL_DAY: lo = 9'sd1;
      default:            lo = 9'sd0;
    endcase
    return lo;
  endfunction

  function automatic cand_t range_hi(sel_t sel);
    cand_t hi;
    unique case (sel)
      SEL_YEAR:               hi = 9'sd99;
      SEL_MONTH:              hi = 9'sd12;
      SEL_DAY:                hi = 9'sd31;
      SEL_HOUR:               hi = 9'sd23;
      SEL_MINUTE, SEL_SECOND: hi = 9'sd59;
      SEL_WEEKDAY:            hi = 9'sd6;
      default:                hi = 9'sd0;
    endcase
    return hi;
  endfunction

endpackage

// ===== hw/rtl/cfa_day_check.sv =====
// ----------------------------------------------------------------------------
// Calendar day check
// Fits a candidate day to the month length, or clamps it for unknown months.
// ----------------------------------------------------------------------------
module cfa_day_check (
  input  cfa_pkg::field_t year,
  input  cfa_pkg::field_t month,
  input  cfa_pkg::cand_t  cand,
  output cfa_pkg::field_t day
);
  import cfa_pkg::*;

  mlen_t len;
  cand_t len_s;
  cand_t fixed;

  always_comb begin
    priority if (month == MONTH_FEB) begin
      len = (year[1:0] == 2'b00) ? LEN_FEB_LEAP : LEN_FEB;
    end else if (month == MONTH_APR || month == MONTH_JUN ||
                 month == MONTH_SEP || month == MONTH_NOV) begin
      len = LEN_SHORT;
    end else if (month >= MONTH_JAN && month <= MONTH_DEC) begin
      len = LEN_LONG;
    end else begin
      len = LEN_UNKNOWN;
    end
  end

  assign len_s = $signed({4'b0000, len});

  always_comb begin
    fixed = cand;
    if (len == LEN_UNKNOWN) begin
      // clamp only
      if (cand < DAY_RAW_MIN) fixed = DAY_RAW_MIN;
      if (cand > DAY_RAW_MAX) fixed = DAY_RAW_MAX;
    end else begin
      priority if (cand > len_s) fixed = DAY_MIN;
      else if (cand < DAY_MIN)   fixed = len_s;
      else                       fixed = cand;
    end
  end

  assign day = fixed[FIELD_W-1:0];

endmodule

// ===== hw/rtl/cfa_field_step.sv =====
// ----------------------------------------------------------------------------
// Calendar field step
// Next field state for one item: move-and-wrap, raw load, day check.
// ----------------------------------------------------------------------------
module cfa_field_step (
  input  cfa_pkg::fields_t cur,
  input  logic [1:0]       operation,
  input  logic [2:0]       field_select,
  input  cfa_pkg::field_t  load_value,
  output cfa_pkg::fields_t nxt
);
  import cfa_pkg::*;

  op_t    op;
  sel_t   sel;
  field_t cur_val;
  cand_t  cand;
  cand_t  lo;
  cand_t  hi;
  cand_t  wrapped;
  field_t wrap_val;
  field_t dc_year;
  field_t dc_month;
  cand_t  dc_cand;
  field_t dc_day;
  field_t wr_val;
  logic   wr_en;

  assign op  = op_t'(operation);
  assign sel = sel_t'(field_select);

  always_comb begin
    unique case (sel)
      SEL_YEAR:    cur_val = cur.year;
      SEL_MONTH:   cur_val = cur.month;
      SEL_DAY:     cur_val = cur.day_of_month;
      SEL_HOUR:    cur_val = cur.hour;
      SEL_MINUTE:  cur_val = cur.minute;
      SEL_SECOND:  cur_val = cur.second;
      SEL_WEEKDAY: cur_val = cur.weekday;
      default:     cur_val = '0;
    endcase
  end

  assign cand = $signed({2'b00, cur_val}) + ((op == OP_INC) ? 9'sd1 : -9'sd1);
  assign lo   = range_lo(sel);
  assign hi   = range_hi(sel);

  always_comb begin
    priority if (cand > hi) wrapped = lo;
    else if (cand < lo)     wrapped = hi;
    else                    wrapped = cand;
  end
  assign wrap_val = wrapped[FIELD_W-1:0];

  // The day check sees the year and month as they stand after this step.
  assign dc_year  = (sel == SEL_YEAR)  ? wrap_val : cur.year;
  assign dc_month = (sel == SEL_MONTH) ? wrap_val : cur.month;
  assign dc_cand  = (sel == SEL_DAY)   ? cand : $signed({2'b00, cur.day_of_month});

  cfa_day_check u_day_check (
    .year  (dc_year),
    .month (dc_month),
    .cand  (dc_cand),
    .day   (dc_day)
  );

  always_comb begin
    unique case (op)
      OP_LOAD: begin
        wr_en  = 1'b1;
        wr_val = load_value;
      end
      OP_INC, OP_DEC: begin
        wr_en  = 1'b1;
        wr_val = (sel == SEL_DAY) ? dc_day : wrap_val;
      end
      default: begin
        wr_en  = 1'b0;
        wr_val = load_value;
      end
    endcase
  end

  always_comb begin
    nxt = cur;
    if (wr_en) begin
      unique case (sel)
        SEL_YEAR:    nxt.year         = wr_val;
        SEL_MONTH:   nxt.month        = wr_val;
        SEL_DAY:     nxt.day_of_month = wr_val;
        SEL_HOUR:    nxt.hour         = wr_val;
        SEL_MINUTE:  nxt.minute       = wr_val;
        SEL_SECOND:  nxt.second       = wr_val;
        SEL_WEEKDAY: nxt.weekday      = wr_val;
        default:     nxt              = cur;
      endcase
      if (op != OP_LOAD && (sel == SEL_YEAR || sel == SEL_MONTH)) begin
        nxt.day_of_month = dc_day;
      end
    end
  end

endmodule

// ===== hw/rtl/calendar_field_adjust_unit.sv =====
// A result item is valid the cycle after its input item is accepted.
// Throughput: one item per cycle unless a pending result is not taken; the field
// state register closes the loop from one item to the next within that cycle.
// in_ready stays high while the result register is empty or being drained.
// Reset (rst_n low, synchronous): all seven fields clear to zero and no
// result is pending.
// ----------------------------------------------------------------------------
// Calendar field adjust unit
// Seven-field date-time register file with increment, decrement and load.
// ----------------------------------------------------------------------------
module calendar_field_adjust_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic [2:0] in_field_select,
  input  logic [6:0] in_load_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_year,
  output logic [6:0] out_month,
  output logic [6:0] out_day_of_month,
  output logic [6:0] out_hour,
  output logic [6:0] out_minute,
  output logic [6:0] out_second,
  output logic [6:0] out_weekday
);
  import cfa_pkg::*;
  `include "calendar_field_adjust_unit_defines.svh"

  // Field state, updated the moment an item is accepted.
  fields_t fields_r;
  fields_t fields_nxt;
  // Result register: snapshot of the state after the accepted item.
  fields_t out_r;
  logic    out_valid_r;
  logic    accept;

  // Take a new item whenever the result register frees up this cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  cfa_field_step u_field_step (
    .cur          (fields_r),
    .operation    (in_operation),
    .field_select (in_field_select),
    .load_value   (in_load_value),
    .nxt          (fields_nxt)
  );

  // Advance the field state on every accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fields_r <= '0;
    end else if (accept) begin
      fields_r <= fields_nxt;
    end
  end

  // Hold the result until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload needs no reset; load it with the new state.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= fields_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_year         = out_r.year;
  assign out_month        = out_r.month;
  assign out_day_of_month = out_r.day_of_month;
  assign out_hour         = out_r.hour;
  assign out_minute       = out_r.minute;
  assign out_second       = out_r.second;
  assign out_weekday      = out_r.weekday;

  // An accepted item always leaves a pending result.
  `CFA_ASSERT_NEXT(a_accept_gives_result, accept, out_valid_r, "accepted item lost its result")
  // The result right after an accept mirrors the new field state.
  `CFA_ASSERT_NEXT(a_result_matches_state, accept, out_r == fields_r, "result differs from state")
  // An ignored field select leaves all fields alone.
  `CFA_ASSERT_NEXT(a_ignored_select_stable, accept && in_field_select == SEL_NONE, fields_r == $past(fields_r), "ignored select changed state")
  // Back-pressure only comes from a pending result that is not taken.
  `CFA_ASSERT_SAME(a_ready_only_when_free, !in_ready, out_valid_r && !out_ready, "in_ready dropped without stall")

endmodule
